// ----- rtl/tpss_pkg.sv -----
`timescale 1ns / 1ps
package tpss_pkg;

    // change point table
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;

    // field widths
    localparam int TIME_W      = 32;
    localparam int WORD_W      = 32;
    localparam int SLOT_W      = 4;
    localparam int COUNT_REG_W = 5;
    localparam int OUT_IDX_W   = 4;

    // stream packing
    localparam int S_TDATA_W   = 104;
    localparam int M_TDATA_W   = 40;

    // configuration port
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_IDX_W-1:0] REG_DURATION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 1'b1;

    // command codes carried in s_tuser
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TIME  = 1'b1;

    // remainder unit: dividend is elapsed + delta, one bit wider than time
    localparam int DVD_W   = TIME_W + 1;
    localparam int DVD_CNT_W = $clog2(DVD_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_FWD,
        S_BWD,
        S_DONE
    } tpss_state_t;

endpackage

// ----- rtl/timed_pattern_step_sequencer.sv -----
// Timed pattern step sequencer: steps through a table of change points (start time, output
// word) as absolute millisecond timestamps arrive. s_tuser selects the command: a table write
// stores one entry and gives no result; a time update produces one result on the m_ side. A
// time update goes straight to the report state when its timestamp did not move forward, or
// when there are no change points or the loop duration is zero. Otherwise it walks the table
// forward and then backward, at most TABLE_DEPTH - 1 steps each way, after first reducing
// elapsed time modulo the loop duration in the remainder unit when it reaches that duration.
// The remainder unit resolves one bit per cycle, and the table walk makes one entry compare
// per cycle. s_tready is high only while the sequencer is idle. A finished result waits in
// the output register, and the next transfer is taken while it waits.
`timescale 1ns / 1ps
module timed_pattern_step_sequencer (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration writes
    input  logic                            cfg_we,
    input  logic [tpss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tpss_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // command stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // entry_index[3:0], entry_time_ms[35:4], entry_output[67:36], timestamp_ms[99:68], zero pad
    input  logic [tpss_pkg::S_TDATA_W-1:0]  s_tdata,
    // command
    input  logic                            s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // current_index[3:0], output_word[35:4], zero pad
    output logic [tpss_pkg::M_TDATA_W-1:0]  m_tdata,
    // valid_res
    output logic                            m_tuser
);
    import tpss_pkg::*;

    // configuration
    logic [TIME_W-1:0]      duration_reg;
    logic [COUNT_REG_W-1:0] change_count_reg;

    // sequencer state
    tpss_state_t       state_reg, state_next;
    logic [TIME_W-1:0] last_ts_reg, last_ts_next;
    logic [TIME_W-1:0] elapsed_reg, elapsed_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    // change point table
    logic [TIME_W-1:0] point_times [TABLE_DEPTH];
    logic [WORD_W-1:0] point_outputs [TABLE_DEPTH];

    // result register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic                 res_valid_reg, res_valid_next;
    logic [OUT_IDX_W-1:0] res_index_reg, res_index_next;
    logic [WORD_W-1:0]    res_word_reg, res_word_next;

    // input fields
    logic [SLOT_W-1:0] in_slot;
    logic [TIME_W-1:0] in_entry_time;
    logic [WORD_W-1:0] in_entry_output;
    logic [TIME_W-1:0] in_timestamp;

    logic              s_xfer;
    logic              tbl_we;
    logic [CNT_W-1:0]  used_count;
    logic [TIME_W-1:0] delta;
    logic [DVD_W-1:0]  sum;
    logic [CNT_W-1:0]  idx_inc;
    logic [IDX_W-1:0]  rd_addr;
    logic              point_started;
    logic [IDX_W-1:0]  rep_idx;
    logic              rem_start;
    logic              rem_done;
    logic [TIME_W-1:0] rem_result;

    assign in_slot         = s_tdata[3:0];
    assign in_entry_time   = s_tdata[35:4];
    assign in_entry_output = s_tdata[67:36];
    assign in_timestamp    = s_tdata[99:68];

    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign tbl_we   = s_xfer && (s_tuser == CMD_WRITE) && (32'(in_slot) < TABLE_DEPTH);

    always_comb begin
        if (32'(change_count_reg) > TABLE_DEPTH) begin
            used_count = CNT_W'(TABLE_DEPTH);
        end else begin
            used_count = CNT_W'(change_count_reg);
        end
    end

    // treat time that went backwards as no movement
    assign delta = (in_timestamp >= last_ts_reg) ? (in_timestamp - last_ts_reg) : '0;
    assign sum   = {1'b0, elapsed_reg} + {1'b0, delta};

    // one table compare per cycle: next entry while walking forward, current entry backward
    assign idx_inc       = {1'b0, idx_reg} + 1'b1;
    assign rd_addr       = (state_reg == S_FWD) ? idx_inc[IDX_W-1:0] : idx_reg;
    assign point_started = (point_times[rd_addr] <= elapsed_reg);

    assign rep_idx = ({1'b0, idx_reg} < count_reg) ? idx_reg : '0;

    always_comb begin
        state_next     = state_reg;
        last_ts_next   = last_ts_reg;
        elapsed_next   = elapsed_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        m_tvalid_next  = m_tvalid_reg;
        res_valid_next = res_valid_reg;
        res_index_next = res_index_reg;
        res_word_next  = res_word_reg;
        rem_start      = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_xfer && (s_tuser == CMD_TIME)) begin
                    last_ts_next = in_timestamp;
                    count_next   = used_count;
                    state_next   = S_DONE;
                    if (delta != '0) begin
                        if (used_count == '0 || duration_reg == '0) begin
                            elapsed_next = '0;
                            idx_next     = '0;
                        end else begin
                            if ({1'b0, idx_reg} >= used_count) begin
                                idx_next = IDX_W'(used_count - 1'b1);
                            end
                            if (sum >= {1'b0, duration_reg}) begin
                                // wrap: reduce in the remainder unit, restart the index
                                idx_next   = '0;
                                rem_start  = 1'b1;
                                state_next = S_MOD;
                            end else begin
                                elapsed_next = sum[TIME_W-1:0];
                                state_next   = S_FWD;
                            end
                        end
                    end
                end
            end
            S_MOD: begin
                if (rem_done) begin
                    elapsed_next = rem_result;
                    state_next   = S_FWD;
                end
            end
            S_FWD: begin
                if (idx_inc < count_reg && point_started) begin
                    idx_next = idx_inc[IDX_W-1:0];
                end else begin
                    state_next = S_BWD;
                end
            end
            S_BWD: begin
                if (idx_reg != '0 && !point_started) begin
                    idx_next = idx_reg - 1'b1;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the result register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    if (count_reg == '0) begin
                        res_valid_next = 1'b0;
                        res_index_next = '0;
                        res_word_next  = '0;
                    end else begin
                        res_valid_next = 1'b1;
                        res_index_next = OUT_IDX_W'(rep_idx);
                        res_word_next  = point_outputs[rep_idx];
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            duration_reg     <= '0;
            change_count_reg <= '0;
            last_ts_reg      <= '0;
            elapsed_reg      <= '0;
            idx_reg          <= '0;
            count_reg        <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            last_ts_reg  <= last_ts_next;
            elapsed_reg  <= elapsed_next;
            idx_reg      <= idx_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_DURATION: duration_reg     <= cfg_wdata[TIME_W-1:0];
                    REG_COUNT:    change_count_reg <= cfg_wdata[COUNT_REG_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        res_valid_reg <= res_valid_next;
        res_index_reg <= res_index_next;
        res_word_reg  <= res_word_next;
    end

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            point_times[IDX_W'(in_slot)]   <= in_entry_time;
            point_outputs[IDX_W'(in_slot)] <= in_entry_output;
        end
    end

    tpss_rem_unit u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (rem_start),
        .dividend  (sum),
        .divisor   (duration_reg),
        .done      (rem_done),
        .remainder (rem_result)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - WORD_W - OUT_IDX_W){1'b0}}, res_word_reg, res_index_reg};
    assign m_tuser  = res_valid_reg;

`ifndef SYNTHESIS
    // the walk never leaves the entries in use
    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FWD || state_reg == S_BWD) |-> ({1'b0, idx_reg} < count_reg))
        else $error("table walk index beyond change count");

    // the remainder unit only finishes while the sequencer waits for it
    a_rem_done_in_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_done |-> (state_reg == S_MOD))
        else $error("remainder done outside modulo state");

    // a new result only comes out of the report state
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside report state");

    // a wrapped walk starts from the first entry
    a_wrap_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MOD) |-> (idx_reg == '0))
        else $error("index not cleared on wrap");
`endif

endmodule

// ----- rtl/tpss_rem_unit.sv -----
`timescale 1ns / 1ps
module tpss_rem_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [tpss_pkg::DVD_W-1:0]  dividend,
    input  logic [tpss_pkg::TIME_W-1:0] divisor,
    output logic                        done,
    output logic [tpss_pkg::TIME_W-1:0] remainder
);
    import tpss_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DVD_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0]     dvd_reg, dvd_next;
    logic [TIME_W-1:0]    dsr_reg, dsr_next;
    logic [TIME_W-1:0]    rem_reg, rem_next;

    logic [DVD_W-1:0]     trial;
    logic [DVD_W-1:0]     diff;

    // restoring remainder, one dividend bit per cycle
    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            // a set top bit of diff means the trial was below the divisor
            rem_next = diff[DVD_W-1] ? trial[TIME_W-1:0] : diff[TIME_W-1:0];
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DVD_CNT_W'(DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
